[hw/rtl/bra_pkg.sv]
// Shared types and operation codes of the banker's resource allocator.
package bra_pkg;
    localparam logic [2:0] FUNC_SET_MAX   = 3'd0;
    localparam logic [2:0] FUNC_SET_AVAIL = 3'd1;
    localparam logic [2:0] FUNC_REQUEST   = 3'd2;
    localparam logic [2:0] FUNC_RELEASE   = 3'd3;
    localparam logic [2:0] FUNC_SAFETY    = 3'd4;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_EXCEED = 2'd1;
    localparam logic [1:0] ST_WAIT   = 2'd2;
    localparam logic [1:0] ST_UNSAFE = 2'd3;

    localparam int AMOUNT_FIELDS = 4;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture input beat
        logic set_max;
        logic set_avail;
        logic release_op;
        logic check;      // compare request against need and avail
        logic commit;     // tentative grant
        logic scan_init;  // work := avail, clear marks, row := 0
        logic scan_step;  // examine one row
        logic rollback;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic exceed;
        logic wait_av;
        logic bad_proc;   // process index outside the tables
        logic row_last;   // current row is last active row
        logic all_done;   // all active rows finished
        logic progress;   // some row finished during this pass
    } t_sts;
endpackage

[hw/rtl/bra_datapath.sv]
// Tables, work vector and row-serial safety scan of the allocator.
module bra_datapath import bra_pkg::*; #(
    parameter int MAX_PROCESSES = 8,
    parameter int MAX_RESOURCES = 4,
    parameter int AMOUNT_BITS   = 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cmd                   i_cmd,
    output t_sts                   o_sts,
    input  logic [2:0]             i_process,
    input  logic [7:0]             i_amount [AMOUNT_FIELDS],
    input  logic [3:0]             i_active_processes,
    input  logic [2:0]             i_active_resources
);
    localparam int PW = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
    localparam int NR = (MAX_RESOURCES < AMOUNT_FIELDS) ? MAX_RESOURCES : AMOUNT_FIELDS;
    localparam logic [AMOUNT_BITS-1:0] AMT_MAX = {AMOUNT_BITS{1'b1}};

    logic [AMOUNT_BITS-1:0] r_need  [MAX_PROCESSES][MAX_RESOURCES];
    logic [AMOUNT_BITS-1:0] r_alloc [MAX_PROCESSES][MAX_RESOURCES];
    logic [AMOUNT_BITS-1:0] r_avail [MAX_RESOURCES];
    logic [AMOUNT_BITS-1:0] r_work  [MAX_RESOURCES];
    logic [AMOUNT_BITS-1:0] r_amt   [MAX_RESOURCES];
    logic [AMOUNT_BITS-1:0] r_old_av [MAX_RESOURCES];
    logic [AMOUNT_BITS-1:0] r_old_al [MAX_RESOURCES];
    logic [AMOUNT_BITS-1:0] r_old_nd [MAX_RESOURCES];
    logic [MAX_PROCESSES-1:0] r_fin;
    logic [PW-1:0]          r_row;
    logic [PW-1:0]          r_proc;
    logic                   r_proc_ok;
    logic                   r_progress;
    logic [6:0]             r_done;

    logic [6:0] np;
    logic [3:0] nr;
    logic [MAX_RESOURCES-1:0] res_en;
    logic fits;
    logic exceed, wait_av;

    always_comb begin
        np = {3'd0, i_active_processes};
        if (np == 7'd0) np = 7'd1;
        if (np > 7'(MAX_PROCESSES)) np = 7'(MAX_PROCESSES);
        nr = {1'b0, i_active_resources};
        if (nr == 4'd0) nr = 4'd1;
        if (nr > 4'(NR)) nr = 4'(NR);
        for (int j = 0; j < MAX_RESOURCES; j++) res_en[j] = (4'(j) < nr);
    end

    always_comb begin
        fits = 1'b1;
        exceed = 1'b0;
        wait_av = 1'b0;
        for (int j = 0; j < MAX_RESOURCES; j++) begin
            if (res_en[j] && r_need[r_row][j] > r_work[j]) fits = 1'b0;
            if (res_en[j] && r_amt[j] > r_need[r_proc][j]) exceed = 1'b1;
            if (res_en[j] && r_amt[j] > r_avail[j]) wait_av = 1'b1;
        end
    end

    assign o_sts.exceed   = exceed;
    assign o_sts.wait_av  = wait_av;
    assign o_sts.bad_proc = !r_proc_ok;
    assign o_sts.row_last = ({1'b0, 6'(r_row)} + 7'd1) >= np;
    assign o_sts.all_done = r_done >= np;
    assign o_sts.progress = r_progress;

    function automatic logic [AMOUNT_BITS-1:0] sat_add(
        input logic [AMOUNT_BITS-1:0] a, input logic [AMOUNT_BITS-1:0] b);
        logic [AMOUNT_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[AMOUNT_BITS] ? AMT_MAX : s[AMOUNT_BITS-1:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_PROCESSES; i++)
                for (int j = 0; j < MAX_RESOURCES; j++) begin
                    r_need[i][j]  <= '0;
                    r_alloc[i][j] <= '0;
                end
            for (int j = 0; j < MAX_RESOURCES; j++) begin
                r_avail[j] <= '0;
                r_work[j]  <= '0;
            end
            r_fin      <= '0;
            r_row      <= '0;
            r_done     <= '0;
            r_progress <= 1'b0;
            r_proc     <= '0;
            r_proc_ok  <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                for (int j = 0; j < MAX_RESOURCES; j++)
                    r_amt[j] <= (j < AMOUNT_FIELDS) ? AMOUNT_BITS'(i_amount[j]) : '0;
                r_proc    <= PW'(i_process);
                r_proc_ok <= ({1'b0, i_process} < 4'(MAX_PROCESSES)) ||
                             (MAX_PROCESSES > 8);
            end
            for (int j = 0; j < MAX_RESOURCES; j++) begin
                if (res_en[j]) begin
                    if (i_cmd.set_max) r_need[r_proc][j] <= r_amt[j];
                    if (i_cmd.set_avail) r_avail[j] <= r_amt[j];
                    if (i_cmd.release_op) begin
                        r_avail[j] <= sat_add(r_avail[j], r_alloc[r_proc][j]);
                        r_need[r_proc][j] <= sat_add(r_need[r_proc][j], r_alloc[r_proc][j]);
                        r_alloc[r_proc][j] <= '0;
                    end
                    if (i_cmd.commit) begin
                        r_old_av[j] <= r_avail[j];
                        r_old_al[j] <= r_alloc[r_proc][j];
                        r_old_nd[j] <= r_need[r_proc][j];
                        r_avail[j] <= r_avail[j] - r_amt[j];
                        r_alloc[r_proc][j] <= sat_add(r_alloc[r_proc][j], r_amt[j]);
                        r_need[r_proc][j] <= r_need[r_proc][j] - r_amt[j];
                    end
                    if (i_cmd.rollback) begin
                        r_avail[j] <= r_old_av[j];
                        r_alloc[r_proc][j] <= r_old_al[j];
                        r_need[r_proc][j] <= r_old_nd[j];
                    end
                end
            end
            if (i_cmd.scan_init) begin
                for (int j = 0; j < MAX_RESOURCES; j++) r_work[j] <= r_avail[j];
                r_fin      <= '0;
                r_row      <= '0;
                r_done     <= '0;
                r_progress <= 1'b0;
            end
            if (i_cmd.scan_step) begin
                if (!r_fin[r_row] && fits) begin
                    for (int j = 0; j < MAX_RESOURCES; j++)
                        if (res_en[j]) r_work[j] <= sat_add(r_work[j], r_alloc[r_row][j]);
                    r_fin[r_row] <= 1'b1;
                    r_done       <= r_done + 7'd1;
                    r_progress   <= 1'b1;
                end else if (r_row == '0) begin
                    // first row of a pass: progress is counted afresh
                    r_progress <= 1'b0;
                end
                if (o_sts.row_last) begin
                    r_row <= '0;
                end else begin
                    r_row <= r_row + PW'(1);
                end
            end
        end
    end
endmodule

[hw/rtl/bra_ctrl.sv]
// Sequencer of the allocator: decode, check, commit, scan, rollback, result.
module bra_ctrl import bra_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [2:0] i_func,
    output t_cmd       o_cmd,
    input  t_sts       i_sts,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [1:0] o_status
);
    typedef enum logic [2:0] {S_IDLE, S_EXEC, S_CHECK, S_INIT, S_SCAN, S_OUT} t_state;

    t_state     r_state;
    logic [2:0] r_func;
    logic       r_valid;
    logic [1:0] r_status;
    logic       r_req;
    logic       r_pass_end;

    // one item in flight; accept once the result register is free
    assign o_stall  = (r_state != S_IDLE) || (r_valid && i_stall);
    assign o_valid  = r_valid;
    assign o_status = r_status;

    logic acc;
    assign acc = i_valid && !o_stall;

    always_comb begin
        o_cmd = '0;
        o_cmd.load = acc;
        case (r_state)
            S_EXEC: begin
                o_cmd.set_max    = (r_func == FUNC_SET_MAX) && !i_sts.bad_proc;
                o_cmd.set_avail  = (r_func == FUNC_SET_AVAIL);
                o_cmd.release_op = (r_func == FUNC_RELEASE) && !i_sts.bad_proc;
                o_cmd.scan_init  = (r_func == FUNC_SAFETY);
            end
            S_CHECK: begin
                o_cmd.commit = !i_sts.exceed && !i_sts.wait_av;
            end
            S_INIT: o_cmd.scan_init = 1'b1;
            S_SCAN: begin
                o_cmd.scan_step = !i_sts.all_done && !r_pass_end;
                o_cmd.rollback  = r_req && r_pass_end && !i_sts.progress && !i_sts.all_done;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_valid    <= 1'b0;
            r_func     <= FUNC_SET_MAX;
            r_status   <= ST_OK;
            r_req      <= 1'b0;
            r_pass_end <= 1'b0;
        end else begin
            if (r_valid && !i_stall) r_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (acc) begin
                        r_func  <= i_func;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_status <= ST_OK;
                    r_req    <= 1'b0;
                    r_pass_end <= 1'b0;
                    case (r_func)
                        FUNC_REQUEST: r_state <= i_sts.bad_proc ? S_OUT : S_CHECK;
                        FUNC_SAFETY:  r_state <= S_SCAN;
                        default:      r_state <= S_OUT;
                    endcase
                end
                S_CHECK: begin
                    if (i_sts.exceed) begin
                        r_status <= ST_EXCEED;
                        r_state  <= S_OUT;
                    end else if (i_sts.wait_av) begin
                        r_status <= ST_WAIT;
                        r_state  <= S_OUT;
                    end else begin
                        r_req   <= 1'b1;
                        r_state <= S_INIT;
                    end
                end
                S_INIT: r_state <= S_SCAN;
                S_SCAN: begin
                    if (i_sts.all_done) begin
                        r_state <= S_OUT;
                    end else if (r_pass_end) begin
                        // end of a full pass with rows still unfinished
                        r_pass_end <= 1'b0;
                        if (!i_sts.progress) begin
                            r_status <= ST_UNSAFE;
                            r_state  <= S_OUT;
                        end
                    end else if (i_sts.row_last) begin
                        r_pass_end <= 1'b1;
                    end
                end
                S_OUT: begin
                    r_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

[hw/rtl/bankers_resource_allocator.sv]
// Banker's resource allocator: one status beat per operation beat. A request that
// passes its check is committed tentatively and then scanned for safety over the P
// active processes (one row examined per cycle, a pass-end step after each pass, up
// to P passes); a safety check scans straight after decode, and other operations
// go from decode to the result. The next beat is taken once the result is delivered
// or its register is free. Requests beyond need or availability are refused without
// changing state, and a grant that leaves no safe finishing order is undone.
module bankers_resource_allocator import bra_pkg::*; #(
    parameter int MAX_PROCESSES = 8,
    parameter int MAX_RESOURCES = 4,
    parameter int AMOUNT_BITS   = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [2:0] i_func,
    input  logic [2:0] i_process,
    input  logic [7:0] i_amount_0,
    input  logic [7:0] i_amount_1,
    input  logic [7:0] i_amount_2,
    input  logic [7:0] i_amount_3,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [1:0] o_status,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_cfg_index,
    input  logic [3:0] i_cfg_data
);
    localparam logic CFG_PROCS = 1'b0;
    localparam logic CFG_RES   = 1'b1;

    logic [3:0] r_active_processes;
    logic [2:0] r_active_resources;
    logic [7:0] amount [AMOUNT_FIELDS];
    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;
    assign amount[0] = i_amount_0;
    assign amount[1] = i_amount_1;
    assign amount[2] = i_amount_2;
    assign amount[3] = i_amount_3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_processes <= 4'd8;
            r_active_resources <= 3'd4;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_PROCS: r_active_processes <= i_cfg_data;
                CFG_RES:   r_active_resources <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    bra_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_func   (i_func),
        .o_cmd    (cmd),
        .i_sts    (sts),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_status (o_status)
    );

    bra_datapath #(
        .MAX_PROCESSES (MAX_PROCESSES),
        .MAX_RESOURCES (MAX_RESOURCES),
        .AMOUNT_BITS   (AMOUNT_BITS)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_sts              (sts),
        .i_process          (i_process),
        .i_amount           (amount),
        .i_active_processes (r_active_processes),
        .i_active_resources (r_active_resources)
    );
endmodule
